FILE: sv/blink_sequencer_with_count_core_assert.svh
// Assertion macros shared by the sequencer RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef BLINK_SEQUENCER_WITH_COUNT_CORE_ASSERT_SVH
`define BLINK_SEQUENCER_WITH_COUNT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

  // Fixed field widths of the stream items
  localparam int OP_BITS     = 3;
  localparam int DT_BITS     = 16;
  localparam int FADE_BITS   = 11;
  localparam int ITEM_BITS   = 24;
  localparam int CFG_IDX_BITS = 3;

  // Fade level is Q1.10; the quotient is built one bit per cycle
  localparam int FADE_FRAC_BITS = 10;
  localparam logic [FADE_BITS-1:0] FADE_CLAMP = 11'd717;
  localparam logic [FADE_BITS-1:0] FADE_FULL  = 11'd1024;
  localparam logic [FADE_BITS-1:0] FADE_NONE  = 11'd0;

  // Register reset values
  localparam int RST_INITIAL_DELAY = 1024;
  localparam int RST_SHOWN_TIME    = 1024;
  localparam int RST_HIDDEN_TIME   = 1024;
  localparam int RST_FADE_START    = 512;
  localparam int RST_END_DELAY     = 0;
  localparam int RST_TOGGLE_COUNT  = 0;
  localparam int RST_LOOP_ENABLE   = 1;
  localparam int RST_START_SHOWN   = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INITIAL_DELAY = 3'd0,
    CFG_SHOWN_TIME    = 3'd1,
    CFG_HIDDEN_TIME   = 3'd2,
    CFG_FADE_START    = 3'd3,
    CFG_END_DELAY     = 3'd4,
    CFG_TOGGLE_COUNT  = 3'd5,
    CFG_LOOP_ENABLE   = 3'd6,
    CFG_START_SHOWN   = 3'd7
  } cfg_idx_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK    = 3'd0,
    OP_ENTER   = 3'd1,
    OP_LEAVE   = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_RESTART = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    PH_INIT   = 2'd0,
    PH_SHOWN  = 2'd1,
    PH_HIDDEN = 2'd2,
    PH_END    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BLK_NONE    = 2'd0,
    BLK_RAISED  = 2'd1,
    BLK_CLEARED = 2'd2
  } block_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic [ITEM_BITS-OP_BITS-DT_BITS-1:0] pad;
    logic [DT_BITS-1:0]                   delta_time;
    op_t                                  operation;
  } in_item_t;

  typedef struct packed {
    logic [ITEM_BITS-FADE_BITS-7-1:0] pad;
    logic                             finish_alert;
    block_t                           block_alert;
    logic [FADE_BITS-1:0]             fade_level;
    logic                             shown_flag;
    logic                             solid;
    phase_t                           phase;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/blink_sequencer_with_count_core.sv
// Flow: an accepted item goes straight to the emit state, or first waits in
//   the divide state when a tick updates the fade level (bit-serial divider).
// The result is then registered into the output register once that is free;
//   no new item is taken until then, so the divider sets the slow case.
// Reset (rst, synchronous): registers return to their defaults, the sequence
//   restarts in the initial delay, run enabled, output register empty.
`default_nettype none

module blink_sequencer_with_count_core #(
  parameter int TIME_BITS  = 24,
  parameter int COUNT_BITS = 8,
  parameter int CFG_BITS   = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [bsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]              cfg_data,
  // input items
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [2:0] operation, [18:3] delta_time, [23:19] zero
  input  wire logic [bsc_pkg::ITEM_BITS-1:0]    s_tdata,
  // result items
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [1:0] phase, [2] solid, [3] shown_flag, [14:4] fade_level,
  // [16:15] block_alert, [17] finish_alert, [23:18] zero
  output logic      [bsc_pkg::ITEM_BITS-1:0]    m_tdata
);

`include "blink_sequencer_with_count_core_assert.svh"

  localparam int SUM_BITS =
    ((TIME_BITS > bsc_pkg::DT_BITS) ? TIME_BITS : bsc_pkg::DT_BITS) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Configuration registers
  logic [TIME_BITS-1:0]  cfg_initial_delay;
  logic [TIME_BITS-1:0]  cfg_shown_time;
  logic [TIME_BITS-1:0]  cfg_hidden_time;
  logic [TIME_BITS-1:0]  cfg_fade_start;
  logic [TIME_BITS-1:0]  cfg_end_delay;
  logic [COUNT_BITS-1:0] cfg_toggle_count;
  logic                  cfg_loop_enable;
  logic                  cfg_start_shown;

  bsc_cfg_regs #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .initial_delay (cfg_initial_delay),
    .shown_time    (cfg_shown_time),
    .hidden_time   (cfg_hidden_time),
    .fade_start    (cfg_fade_start),
    .end_delay     (cfg_end_delay),
    .toggle_count  (cfg_toggle_count),
    .loop_enable   (cfg_loop_enable),
    .start_shown   (cfg_start_shown)
  );

  // Sequencer state
  bsc_pkg::state_t       state;
  bsc_pkg::state_t       state_next;
  bsc_pkg::phase_t       phase_reg;
  logic [TIME_BITS-1:0]  elapsed;
  logic [COUNT_BITS-1:0] toggles_left;
  logic                  counting;
  logic                  shown_reg;
  logic                  solid_reg;
  logic [bsc_pkg::FADE_BITS-1:0] fade_reg;
  logic                  occupied;
  logic                  finished;
  logic                  run_enabled;
  bsc_pkg::block_t       block_reg;
  logic                  fin_reg;

  // Step results for the item on the input
  bsc_pkg::in_item_t     in_item;
  bsc_pkg::out_item_t    out_item;
  bsc_pkg::phase_t       phase_next;
  logic [TIME_BITS-1:0]  elapsed_next;
  logic [COUNT_BITS-1:0] toggles_left_next;
  logic                  counting_next;
  logic                  shown_next;
  logic                  solid_next;
  logic [bsc_pkg::FADE_BITS-1:0] fade_next;
  logic                  occupied_next;
  logic                  finished_next;
  logic                  run_enabled_next;
  bsc_pkg::block_t       block_next;
  logic                  fin_next;
  logic                  fade_go;

  logic [SUM_BITS-1:0]   el_sum;
  logic [TIME_BITS-1:0]  el_sat;
  logic [COUNT_BITS-1:0] toggles_dec;

  logic                  accept;
  logic                  load_out;
  logic                  div_start;
  logic                  div_done;
  logic [bsc_pkg::FADE_BITS-1:0] div_level;

  assign in_item = bsc_pkg::in_item_t'(s_tdata);
  assign s_tready = (state == bsc_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign div_start = accept && fade_go;
  assign m_tdata  = out_item;

  // Saturating tick add: clamp elapsed at the top of the time range
  assign el_sum = SUM_BITS'(elapsed) + SUM_BITS'(in_item.delta_time);
  assign el_sat = (el_sum > SUM_BITS'(TIME_MAX)) ? TIME_MAX : el_sum[TIME_BITS-1:0];

  // Each shown/hidden change uses one toggle while counting, never going below zero
  assign toggles_dec = (counting && (toggles_left != '0)) ? (toggles_left - 1'b1)
                                                          : toggles_left;

  // Work out the state after one item. The fade quotient is left to the
  // divider; fade_go flags that it must replace the fade level.
  always_comb begin
    phase_next        = phase_reg;
    elapsed_next      = elapsed;
    toggles_left_next = toggles_left;
    counting_next     = counting;
    shown_next        = shown_reg;
    solid_next        = solid_reg;
    fade_next         = fade_reg;
    occupied_next     = occupied;
    finished_next     = finished;
    run_enabled_next  = run_enabled;
    block_next        = bsc_pkg::BLK_NONE;
    fin_next          = 1'b0;
    fade_go           = 1'b0;
    unique case (in_item.operation)
      bsc_pkg::OP_TICK: begin
        // Out of toggles: jump to the end delay, even while disabled
        if (counting && (toggles_left == '0)) begin
          phase_next = bsc_pkg::PH_END;
        end
        if (run_enabled) begin
          elapsed_next = el_sat;
          unique case (phase_next)
            bsc_pkg::PH_INIT: begin
              if (el_sat > cfg_initial_delay) begin
                phase_next   = cfg_start_shown ? bsc_pkg::PH_SHOWN : bsc_pkg::PH_HIDDEN;
                elapsed_next = '0;
              end
            end
            bsc_pkg::PH_SHOWN: begin
              if (el_sat > cfg_shown_time) begin
                // Leaving shown overrides any fade update
                toggles_left_next = toggles_dec;
                shown_next        = 1'b0;
                solid_next        = 1'b0;
                fade_next         = bsc_pkg::FADE_FULL;
                phase_next        = bsc_pkg::PH_HIDDEN;
                elapsed_next      = '0;
                if (occupied) begin
                  block_next = bsc_pkg::BLK_RAISED;
                end
              end else if (el_sat > cfg_fade_start) begin
                fade_go = 1'b1;
              end
            end
            bsc_pkg::PH_HIDDEN: begin
              if (el_sat > cfg_hidden_time) begin
                toggles_left_next = toggles_dec;
                shown_next        = 1'b1;
                solid_next        = 1'b1;
                fade_next         = bsc_pkg::FADE_NONE;
                phase_next        = bsc_pkg::PH_SHOWN;
                elapsed_next      = '0;
              end
            end
            bsc_pkg::PH_END: begin
              if (el_sat > cfg_end_delay) begin
                elapsed_next = '0;
                shown_next   = cfg_start_shown;
                if (cfg_loop_enable) begin
                  phase_next        = bsc_pkg::PH_INIT;
                  toggles_left_next = cfg_toggle_count;
                end else begin
                  // Finish: report once, then hold in the end delay
                  phase_next        = bsc_pkg::PH_END;
                  toggles_left_next = '0;
                  if (!finished) begin
                    fin_next      = 1'b1;
                    finished_next = 1'b1;
                  end
                end
              end
            end
          endcase
        end
      end
      bsc_pkg::OP_ENTER: begin
        occupied_next = 1'b1;
        if (!shown_reg) begin
          block_next = bsc_pkg::BLK_RAISED;
        end
      end
      bsc_pkg::OP_LEAVE: begin
        occupied_next = 1'b0;
        block_next    = bsc_pkg::BLK_CLEARED;
      end
      bsc_pkg::OP_ENABLE, bsc_pkg::OP_RESTART: begin
        // Reload the run from the registers; enable also resumes time
        if (in_item.operation == bsc_pkg::OP_ENABLE) begin
          run_enabled_next = 1'b1;
        end
        phase_next        = bsc_pkg::PH_INIT;
        shown_next        = cfg_start_shown;
        solid_next        = cfg_start_shown;
        fade_next         = cfg_start_shown ? bsc_pkg::FADE_NONE : bsc_pkg::FADE_FULL;
        occupied_next     = 1'b0;
        toggles_left_next = cfg_toggle_count;
        counting_next     = (cfg_toggle_count != '0);
        elapsed_next      = '0;
        finished_next     = 1'b0;
      end
      bsc_pkg::OP_DISABLE: begin
        run_enabled_next = 1'b0;
      end
      default: begin
        // unused operation codes leave the state alone
      end
    endcase
  end

  bsc_fade_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (elapsed_next),
    .den   (cfg_shown_time),
    .done  (div_done),
    .level (div_level)
  );

  // Control: take an item, wait for the divider if needed, then hand the
  // result to the output register as soon as it is free.
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      bsc_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = fade_go ? bsc_pkg::S_DIV : bsc_pkg::S_EMIT;
        end
      end
      bsc_pkg::S_DIV: begin
        if (div_done) begin
          state_next = bsc_pkg::S_EMIT;
        end
      end
      bsc_pkg::S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = bsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bsc_pkg::S_IDLE;
      m_tvalid     <= 1'b0;
      phase_reg    <= bsc_pkg::PH_INIT;
      elapsed      <= '0;
      toggles_left <= COUNT_BITS'(bsc_pkg::RST_TOGGLE_COUNT);
      counting     <= (bsc_pkg::RST_TOGGLE_COUNT != 0);
      shown_reg    <= 1'(bsc_pkg::RST_START_SHOWN);
      solid_reg    <= 1'(bsc_pkg::RST_START_SHOWN);
      fade_reg     <= (bsc_pkg::RST_START_SHOWN != 0) ? bsc_pkg::FADE_NONE
                                                      : bsc_pkg::FADE_FULL;
      occupied     <= 1'b0;
      finished     <= 1'b0;
      run_enabled  <= 1'b1;
    end else begin
      state <= state_next;
      if (accept) begin
        phase_reg    <= phase_next;
        elapsed      <= elapsed_next;
        toggles_left <= toggles_left_next;
        counting     <= counting_next;
        shown_reg    <= shown_next;
        solid_reg    <= solid_next;
        fade_reg     <= fade_next;
        occupied     <= occupied_next;
        finished     <= finished_next;
        run_enabled  <= run_enabled_next;
      end else if ((state == bsc_pkg::S_DIV) && div_done) begin
        fade_reg <= div_level;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Per-item alerts and the output register hold payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      block_reg <= block_next;
      fin_reg   <= fin_next;
    end
    if (load_out) begin
      out_item.pad          <= '0;
      out_item.phase        <= phase_reg;
      out_item.solid        <= solid_reg;
      out_item.shown_flag   <= shown_reg;
      out_item.fade_level   <= fade_reg;
      out_item.block_alert  <= block_reg;
      out_item.finish_alert <= fin_reg;
    end
  end

  `BSC_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready,
                   "item accepted but block still ready next cycle")
  `BSC_ASSERT_HOLDS(a_div_done_state, div_done, state == bsc_pkg::S_DIV,
                    "divider finished outside the divide wait")
  `BSC_ASSERT_HOLDS(a_finish_in_end, m_tvalid && out_item.finish_alert,
                    out_item.phase == bsc_pkg::PH_END,
                    "finish alert outside the end delay")
  `BSC_ASSERT_HOLDS(a_fade_range, m_tvalid,
                    out_item.fade_level <= bsc_pkg::FADE_FULL,
                    "fade level above fully hidden")

endmodule

`default_nettype wire

FILE: sv/bsc_cfg_regs.sv
`default_nettype none

module bsc_cfg_regs #(
  parameter int TIME_BITS  = 24,
  parameter int COUNT_BITS = 8,
  parameter int CFG_BITS   = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [bsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]              cfg_data,
  output logic      [TIME_BITS-1:0]             initial_delay,
  output logic      [TIME_BITS-1:0]             shown_time,
  output logic      [TIME_BITS-1:0]             hidden_time,
  output logic      [TIME_BITS-1:0]             fade_start,
  output logic      [TIME_BITS-1:0]             end_delay,
  output logic      [COUNT_BITS-1:0]            toggle_count,
  output logic                                  loop_enable,
  output logic                                  start_shown
);

  logic [TIME_BITS-1:0]  wr_time;
  logic [COUNT_BITS-1:0] wr_count;

  assign wr_time  = cfg_data[TIME_BITS-1:0];
  assign wr_count = cfg_data[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay <= TIME_BITS'(bsc_pkg::RST_INITIAL_DELAY);
      shown_time    <= TIME_BITS'(bsc_pkg::RST_SHOWN_TIME);
      hidden_time   <= TIME_BITS'(bsc_pkg::RST_HIDDEN_TIME);
      fade_start    <= TIME_BITS'(bsc_pkg::RST_FADE_START);
      end_delay     <= TIME_BITS'(bsc_pkg::RST_END_DELAY);
      toggle_count  <= COUNT_BITS'(bsc_pkg::RST_TOGGLE_COUNT);
      loop_enable   <= 1'(bsc_pkg::RST_LOOP_ENABLE);
      start_shown   <= 1'(bsc_pkg::RST_START_SHOWN);
    end else if (cfg_we) begin
      unique case (bsc_pkg::cfg_idx_t'(cfg_index))
        bsc_pkg::CFG_INITIAL_DELAY: initial_delay <= wr_time;
        bsc_pkg::CFG_SHOWN_TIME:    shown_time    <= wr_time;
        bsc_pkg::CFG_HIDDEN_TIME:   hidden_time   <= wr_time;
        bsc_pkg::CFG_FADE_START:    fade_start    <= wr_time;
        bsc_pkg::CFG_END_DELAY:     end_delay     <= wr_time;
        bsc_pkg::CFG_TOGGLE_COUNT:  toggle_count  <= wr_count;
        bsc_pkg::CFG_LOOP_ENABLE:   loop_enable   <= cfg_data[0];
        bsc_pkg::CFG_START_SHOWN:   start_shown   <= cfg_data[0];
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/bsc_fade_div.sv
`default_nettype none

// Restoring divider: level = min(num * 1024 / den, clamp).
// One quotient bit per cycle shifts into quot; a dividend at or above the
// divisor (including a zero divisor) means a quotient of 1024 or more.
module bsc_fade_div #(
  parameter int TIME_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [TIME_BITS-1:0]          num,
  input  wire logic [TIME_BITS-1:0]          den,
  output logic                               done,
  output logic      [bsc_pkg::FADE_BITS-1:0] level
);

  localparam int FRAC     = bsc_pkg::FADE_FRAC_BITS;
  localparam int CNT_BITS = $clog2(FRAC);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] den_reg;
  logic [FRAC-1:0]      quot;
  logic                 sat;
  logic [TIME_BITS:0]   rem_dbl;
  logic [TIME_BITS:0]   rem_sub;
  logic                 ge;

  assign rem_dbl = {rem, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, den_reg};
  assign ge      = rem_dbl >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt     <= CNT_BITS'(FRAC - 1);
      rem     <= num;
      den_reg <= den;
      sat     <= num >= den;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      rem  <= ge ? rem_sub[TIME_BITS-1:0] : rem_dbl[TIME_BITS-1:0];
      quot <= {quot[FRAC-2:0], ge};
    end
  end

  always_comb begin
    if (sat || ({1'b0, quot} > bsc_pkg::FADE_CLAMP)) begin
      level = bsc_pkg::FADE_CLAMP;
    end else begin
      level = {1'b0, quot};
    end
  end

endmodule

`default_nettype wire
